>>> rtl/mme_pkg.sv
// Shared types and constants for the Montgomery modular exponentiation block.
// Holds the sequencer state type, register indexes and port widths.
// No dependencies.
package mme_pkg;

    localparam int DATA_W    = 64;
    localparam int MOD_W     = 63;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_R_SQUARED = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_Z_INIT,
        ST_P_INIT,
        ST_EXP,
        ST_MUL_Z,
        ST_SQR_P,
        ST_FINAL
    } state_t;

endpackage

>>> rtl/montgomery_modular_exponentiation.sv
// Montgomery modular exponentiation: base^exponent mod modulus.
// Depends on mme_pkg and mme_mont_mul.
//
// Usage: write modulus (odd, below 2^63), exponent and R^2 mod N through
// cfg_we / cfg_index / cfg_data while the block is idle; writes take effect
// at once, an unused index is ignored. An item is taken when start is high
// and busy is low. busy then stays high until the result is shown.
// The result is held on modular_power and done is high for one cycle; the
// receiver cannot hold it off, and a new item may be started in that cycle.
// All multiplies run one at a time on the single bit-serial Montgomery
// multiplier: two pre-scale multiplies, one square per exponent bit plus
// one multiply per set bit, and one unscale multiply. Each exponent bit is
// first inspected in the EXP state before its multiplies are launched.
// Reset clears the sequencer and restores modulus 1, exponent 0 and
// R^2 mod N of 0; no result is pending after reset.
module montgomery_modular_exponentiation #(
    parameter int WIDTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mme_pkg::DATA_W-1:0]          base,
    output logic                                done,
    output logic [mme_pkg::DATA_W-1:0]          modular_power,
    input  logic                                cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mme_pkg::DATA_W-1:0]          cfg_data
);

    localparam int CW = $clog2(WIDTH);

    mme_pkg::state_t state_reg, state_next;

    logic [mme_pkg::MOD_W-1:0]  modulus_reg;
    logic [mme_pkg::DATA_W-1:0] exponent_reg;
    logic [mme_pkg::MOD_W-1:0]  r_squared_reg;

    logic [WIDTH-1:0]           base_reg, base_next;
    logic [WIDTH-1:0]           z_reg, z_next;
    logic [WIDTH-1:0]           p_reg, p_next;
    logic [WIDTH-1:0]           exp_sh_reg, exp_sh_next;
    logic [CW-1:0]              exp_cnt_reg, exp_cnt_next;
    logic [mme_pkg::DATA_W-1:0] power_reg, power_next;
    logic                       done_reg, done_next;

    logic                       mm_start;
    logic [WIDTH-1:0]           mm_x;
    logic [WIDTH-1:0]           mm_y;
    logic                       mm_busy;
    logic                       mm_done;
    logic [WIDTH-1:0]           mm_result;

    logic [WIDTH-1:0]           one_w;
    logic [WIDTH-1:0]           r2_w;
    logic [WIDTH-1:0]           n_w;

    assign one_w = WIDTH'(1);
    assign r2_w  = WIDTH'(r_squared_reg);
    assign n_w   = WIDTH'(modulus_reg);

    mme_mont_mul #(
        .WIDTH (WIDTH)
    ) u_mont_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .x_in   (mm_x),
        .y_in   (mm_y),
        .n_in   (n_w),
        .busy   (mm_busy),
        .done   (mm_done),
        .result (mm_result)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= mme_pkg::MOD_W'(1);
            exponent_reg  <= '0;
            r_squared_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mme_pkg::CFG_MODULUS:   modulus_reg   <= cfg_data[mme_pkg::MOD_W-1:0];
                mme_pkg::CFG_EXPONENT:  exponent_reg  <= cfg_data;
                mme_pkg::CFG_R_SQUARED: r_squared_reg <= cfg_data[mme_pkg::MOD_W-1:0];
                default:                ;
            endcase
        end
    end

    // sequencer: launches each multiply on start, from the EXP state, or as the previous one finishes
    always_comb
    begin
        state_next   = state_reg;
        base_next    = base_reg;
        z_next       = z_reg;
        p_next       = p_reg;
        exp_sh_next  = exp_sh_reg;
        exp_cnt_next = exp_cnt_reg;
        power_next   = power_reg;
        done_next    = 1'b0;
        mm_start     = 1'b0;
        mm_x         = one_w;
        mm_y         = r2_w;
        case (state_reg)
            mme_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    base_next  = WIDTH'(base);
                    mm_start   = 1'b1;
                    state_next = mme_pkg::ST_Z_INIT;
                end
            end
            mme_pkg::ST_Z_INIT:
            begin
                if (mm_done)
                begin
                    z_next     = mm_result;
                    mm_start   = 1'b1;
                    mm_x       = r2_w;
                    mm_y       = base_reg;
                    state_next = mme_pkg::ST_P_INIT;
                end
            end
            mme_pkg::ST_P_INIT:
            begin
                if (mm_done)
                begin
                    p_next       = mm_result;
                    exp_sh_next  = WIDTH'(exponent_reg);
                    exp_cnt_next = '0;
                    state_next   = mme_pkg::ST_EXP;
                end
            end
            mme_pkg::ST_EXP:
            begin
                mm_start = 1'b1;
                if (exp_sh_reg[0])
                begin
                    mm_x       = z_reg;
                    mm_y       = p_reg;
                    state_next = mme_pkg::ST_MUL_Z;
                end
                else
                begin
                    mm_x       = p_reg;
                    mm_y       = p_reg;
                    state_next = mme_pkg::ST_SQR_P;
                end
            end
            mme_pkg::ST_MUL_Z:
            begin
                if (mm_done)
                begin
                    z_next     = mm_result;
                    mm_start   = 1'b1;
                    mm_x       = p_reg;
                    mm_y       = p_reg;
                    state_next = mme_pkg::ST_SQR_P;
                end
            end
            mme_pkg::ST_SQR_P:
            begin
                if (mm_done)
                begin
                    p_next      = mm_result;
                    exp_sh_next = {1'b0, exp_sh_reg[WIDTH-1:1]};
                    if (exp_cnt_reg == CW'(WIDTH - 1))
                    begin
                        // unscale the accumulator
                        mm_start   = 1'b1;
                        mm_x       = one_w;
                        mm_y       = z_reg;
                        state_next = mme_pkg::ST_FINAL;
                    end
                    else
                    begin
                        exp_cnt_next = exp_cnt_reg + 1'b1;
                        state_next   = mme_pkg::ST_EXP;
                    end
                end
            end
            mme_pkg::ST_FINAL:
            begin
                if (mm_done)
                begin
                    power_next = mme_pkg::DATA_W'(mm_result);
                    done_next  = 1'b1;
                    state_next = mme_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mme_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mme_pkg::ST_IDLE;
            exp_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            exp_cnt_reg <= exp_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        z_reg      <= z_next;
        p_reg      <= p_next;
        exp_sh_reg <= exp_sh_next;
        power_reg  <= power_next;
    end

    assign busy          = (state_reg != mme_pkg::ST_IDLE);
    assign done          = done_reg;
    assign modular_power = power_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while sequencer still busy");

    a_launch_free: assert property (@(posedge clk) disable iff (!rst_n)
        mm_start |-> !mm_busy)
        else $error("multiply launched while multiplier busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_final_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mme_pkg::ST_FINAL) |-> (exp_cnt_reg == CW'(WIDTH - 1)))
        else $error("unscale step entered before all exponent bits");

endmodule

>>> rtl/mme_mont_mul.sv
// Bit-serial radix-2 Montgomery multiplier, one operand bit per cycle.
// Computes x * y * 2^-WIDTH without final subtraction. Standalone;
// the modulus input must stay stable while busy.
module mme_mont_mul #(
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] x_in,
    input  logic [WIDTH-1:0] y_in,
    input  logic [WIDTH-1:0] n_in,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] result
);

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] x_reg, x_next;
    logic [WIDTH-1:0] y_reg, y_next;
    logic [WIDTH-1:0] t_reg, t_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [WIDTH-1:0] addend_y;
    logic [WIDTH-1:0] addend_n;
    logic             odd;
    logic [WIDTH+1:0] sum;

    always_comb
    begin
        addend_y = x_reg[0] ? y_reg : '0;
        // parity of t plus the y addend decides whether the modulus is added
        odd      = t_reg[0] ^ (x_reg[0] & y_reg[0]);
        addend_n = odd ? n_in : '0;
        sum      = {2'b00, t_reg} + {2'b00, addend_y} + {2'b00, addend_n};
    end

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        t_next    = t_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = x_in;
            y_next    = y_in;
            t_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift right and drop anything above WIDTH bits
            t_next = sum[WIDTH:1];
            x_next = {1'b0, x_reg[WIDTH-1:1]};
            if (cnt_reg == CW'(WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        t_reg <= t_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = t_reg;

endmodule
